/* rtl/core/idpe_pkg.sv */
// idpe_pkg: shared constants and types of the inverse distance position estimator
// used by idpe_lane, idpe_merge and the top level; no dependencies
package idpe_pkg;

  localparam int unsigned SENSOR_SLOTS    = 7;
  localparam int unsigned NUM_SENSORS_DEF = 7;
  localparam int unsigned DIST_W          = 16;
  localparam int unsigned MASK_W          = 7;
  localparam int unsigned ERR_W           = 15;

  // weight = floor(2^32 / (1024*d + 1)), restoring divider one bit a stage
  localparam int unsigned DIVR_W    = DIST_W + 10;
  localparam int unsigned WGT_W     = 33;
  localparam int unsigned WGT_STEPS = WGT_W;
  localparam int unsigned LANE_LAT  = WGT_STEPS + 1;

  // merge: sums, sign/magnitude, quotient bits, output
  localparam int unsigned DEN_W     = WGT_W + 3;
  localparam int unsigned MAG_W     = WGT_W + 5;
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned QUO_W     = 14;
  localparam int unsigned REM_W     = MAG_W + FRAC_W + 1;
  localparam int unsigned MERGE_LAT = QUO_W + 3;
  localparam int unsigned TOTAL_LAT = LANE_LAT + MERGE_LAT;

  localparam logic [DIST_W-1:0] LIMIT_RST = 16'd1000;
  localparam logic [MASK_W-1:0] ENMASK_RST = 7'h7F;

  // register indexes
  typedef enum logic [0:0] {
    REG_LIMIT  = 1'b0,
    REG_ENMASK = 1'b1
  } cfg_reg_e;

  typedef logic [SENSOR_SLOTS-1:0][DIST_W-1:0] dist_vec_t;
  typedef logic [SENSOR_SLOTS-1:0][WGT_W-1:0]  wgt_vec_t;

endpackage

/* rtl/core/idpe_lane.sv */
// idpe_lane: clamps one sensor reading and computes its inverse distance weight
// depends on idpe_pkg
module idpe_lane import idpe_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              active_i,
  input  logic              ok_i,
  input  logic [DIST_W-1:0] raw_i,
  input  logic [DIST_W-1:0] limit_i,
  output logic [WGT_W-1:0]  weight_o,
  output logic [DIST_W-1:0] clamped_o,
  output logic              near_o
);

  logic [DIVR_W-1:0] dv_q  [LANE_LAT];
  logic [DIVR_W-1:0] rem_q [LANE_LAT];
  logic [WGT_W-1:0]  quo_q [LANE_LAT];
  logic [DIST_W-1:0] cl_q  [LANE_LAT];
  logic              act_q [LANE_LAT];
  logic              nr_q  [LANE_LAT];

  logic [DIST_W-1:0] dist_d;

  // clamp or substitute the threshold
  always_comb begin
    dist_d = limit_i;
    if (active_i && ok_i && (raw_i < limit_i)) begin
      dist_d = raw_i;
    end
  end

  // entry stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0]  <= {dist_d, 10'b0000000001};
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      cl_q[0]  <= dist_d;
      act_q[0] <= active_i;
      nr_q[0]  <= active_i && (dist_d < limit_i);
    end
  end

  // one quotient bit a stage, dividend is 2^32 so only the first bit is set
  for (genvar j = 0; j < WGT_STEPS; j++) begin : g_step
    logic [DIVR_W:0] trial;
    logic            ge;
    always_comb begin
      trial = {rem_q[j], (j == 0) ? 1'b1 : 1'b0};
      ge    = trial >= {1'b0, dv_q[j]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1]  <= dv_q[j];
        rem_q[j+1] <= ge ? DIVR_W'(trial - {1'b0, dv_q[j]}) : trial[DIVR_W-1:0];
        quo_q[j+1] <= {quo_q[j][WGT_W-2:0], ge};
        cl_q[j+1]  <= cl_q[j];
        act_q[j+1] <= act_q[j];
        nr_q[j+1]  <= nr_q[j];
      end
    end
  end

  assign weight_o  = act_q[LANE_LAT-1] ? quo_q[LANE_LAT-1] : '0;
  assign clamped_o = cl_q[LANE_LAT-1];
  assign near_o    = nr_q[LANE_LAT-1];

endmodule

/* rtl/core/idpe_merge.sv */
// idpe_merge: combines lane weights into the weighted mean position
// depends on idpe_pkg
module idpe_merge import idpe_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  wgt_vec_t          weight_i,
  input  dist_vec_t         clamped_i,
  input  logic [MASK_W-1:0] near_i,
  output dist_vec_t         clamped_o,
  output logic [MASK_W-1:0] near_o,
  output logic [ERR_W-1:0]  err_o
);

  localparam int unsigned NDIV = QUO_W + 1;

  logic [DEN_W-1:0] den_lo_q, den_hi_q;
  logic [MAG_W-1:0] pos_q, neg_q;
  dist_vec_t        cl_q [MERGE_LAT];
  logic [MASK_W-1:0] nr_q [MERGE_LAT];

  logic [DEN_W-1:0] den_q [NDIV];
  logic [REM_W-1:0] rem_q [NDIV];
  logic [QUO_W-1:0] quo_q [NDIV];
  logic             sgn_q [NDIV];
  logic [ERR_W-1:0] err_q;

  logic [DEN_W-1:0] den_lo_d, den_hi_d;
  logic [MAG_W-1:0] pos_d, neg_d;

  // partial sums of weights and of weight times position
  always_comb begin
    den_lo_d = '0;
    den_hi_d = '0;
    pos_d    = '0;
    neg_d    = '0;
    for (int i = 0; i < SENSOR_SLOTS; i++) begin
      if (i < 4) den_lo_d = den_lo_d + DEN_W'(weight_i[i]);
      else       den_hi_d = den_hi_d + DEN_W'(weight_i[i]);
      if (i > 3) pos_d = pos_d + MAG_W'(weight_i[i]) * MAG_W'(i - 3);
      if (i < 3) neg_d = neg_d + MAG_W'(weight_i[i]) * MAG_W'(3 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_lo_q <= den_lo_d;
      den_hi_q <= den_hi_d;
      pos_q    <= pos_d;
      neg_q    <= neg_d;
      cl_q[0]  <= clamped_i;
      nr_q[0]  <= near_i;
    end
  end

  // sign and magnitude, dividend scaled by 2^12
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_lo_q + den_hi_q;
      sgn_q[0] <= neg_q > pos_q;
      rem_q[0] <= REM_W'((neg_q > pos_q) ? (neg_q - pos_q) : (pos_q - neg_q)) << FRAC_W;
      quo_q[0] <= '0;
      cl_q[1]  <= cl_q[0];
      nr_q[1]  <= nr_q[0];
    end
  end

  // quotient is below 2^14, one bit a stage from the top
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [REM_W-1:0] sub;
    logic             ge;
    always_comb begin
      sub = REM_W'(den_q[k]) << (QUO_W - 1 - k);
      ge  = rem_q[k] >= sub;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= den_q[k];
        sgn_q[k+1] <= sgn_q[k];
        rem_q[k+1] <= ge ? (rem_q[k] - sub) : rem_q[k];
        quo_q[k+1] <= {quo_q[k][QUO_W-2:0], ge};
        cl_q[k+2]  <= cl_q[k+1];
        nr_q[k+2]  <= nr_q[k+1];
      end
    end
  end

  // apply sign, no sensor taking part gives zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (den_q[NDIV-1] == '0) begin
        err_q <= '0;
      end else if (sgn_q[NDIV-1]) begin
        err_q <= ERR_W'(-{1'b0, quo_q[NDIV-1]});
      end else begin
        err_q <= {1'b0, quo_q[NDIV-1]};
      end
      cl_q[MERGE_LAT-1] <= cl_q[MERGE_LAT-2];
      nr_q[MERGE_LAT-1] <= nr_q[MERGE_LAT-2];
    end
  end

  assign clamped_o = cl_q[MERGE_LAT-1];
  assign near_o    = nr_q[MERGE_LAT-1];
  assign err_o     = err_q;

endmodule

/* rtl/core/inverse_distance_position_estimator.sv */
// inverse_distance_position_estimator: top level, seven weight lanes and a merge stage
// depends on idpe_pkg, idpe_lane, idpe_merge
//
//  channel   direction  width  content
//  s_axis    in         120    seven raw ranges, range ok mask
//  m_axis    out        136    seven clamped ranges, near mask, position error
//  cfg       in         16     distance limit (index 0), enabled mask (index 1)
//
//  one item enters per cycle while the output is not stalled; each item passes through its lane and the merge
//  each lane holds a 33 stage weight divider and the merge a 14 stage quotient divider
//  the whole pipeline advances whenever the output register is empty or taken
//  reset clears the valid bits and sets the registers to limit 1000, all sensors on
module inverse_distance_position_estimator import idpe_pkg::*; #(
  parameter int unsigned NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [119:0]  s_axis_tdata,  // distance_0..distance_6, range_ok_mask, pad
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,  // clamped_0..clamped_6, near_mask, position_error, pad
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic [DIST_W-1:0]    limit_q;
  logic [MASK_W-1:0]    enmask_q;
  logic [TOTAL_LAT-1:0] vld_q;
  logic                 adv;

  wgt_vec_t          weight;
  dist_vec_t         lane_cl, out_cl;
  logic [MASK_W-1:0] lane_nr, out_nr;
  logic [ERR_W-1:0]  out_err;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      enmask_q <= ENMASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LIMIT:  limit_q  <= cfg_wdata_i;
        REG_ENMASK: enmask_q <= cfg_wdata_i[MASK_W-1:0];
        default:    ;
      endcase
    end
  end

  // pipeline advance and valid chain
  assign adv           = !vld_q[TOTAL_LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], s_axis_tvalid};
    end
  end

  // weight lanes
  for (genvar i = 0; i < SENSOR_SLOTS; i++) begin : g_lane
    idpe_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (adv),
      .active_i  ((i < NUM_SENSORS) && enmask_q[i]),
      .ok_i      (s_axis_tdata[SENSOR_SLOTS*DIST_W + i]),
      .raw_i     (s_axis_tdata[i*DIST_W +: DIST_W]),
      .limit_i   (limit_q),
      .weight_o  (weight[i]),
      .clamped_o (lane_cl[i]),
      .near_o    (lane_nr[i])
    );
  end

  idpe_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (adv),
    .weight_i  (weight),
    .clamped_i (lane_cl),
    .near_i    (lane_nr),
    .clamped_o (out_cl),
    .near_o    (out_nr),
    .err_o     (out_err)
  );

  assign m_axis_tvalid = vld_q[TOTAL_LAT-1];
  assign m_axis_tdata  = {2'b00, out_err, out_nr, out_cl};

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input ready follows the output register state
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow pipeline advance");

  // error magnitude stays within three sensor pitches
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(out_err) <= 15'sd12288) && ($signed(out_err) >= -15'sd12288))
    else $error("position error out of range");

endmodule

/* tb/inverse_distance_position_estimator_test.sv */
// inverse_distance_position_estimator_test: self-checking bench for the position estimator
// depends on idpe_pkg and inverse_distance_position_estimator
module inverse_distance_position_estimator_test;
  import idpe_pkg::*;

  typedef struct packed {
    logic [6:0]  near;
    logic [14:0] perr;
    dist_vec_t   clamped;
  } frame_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [119:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;
  logic          cfg_we_i = 1'b0;
  logic [0:0]    cfg_idx_i = REG_LIMIT;
  logic [15:0]   cfg_wdata_i = '0;

  inverse_distance_position_estimator dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [15:0]   limit_q = LIMIT_RST;
  logic [6:0]    enmask_q = ENMASK_RST;
  frame_result_t expected_q[$];
  int            errors = 0;
  int            results_seen = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_off = 1'b0;
  longint        cycles = 0;

  function automatic frame_result_t predict_frame(dist_vec_t raw, logic [6:0] ok);
    frame_result_t r;
    logic [15:0]   d;
    logic [32:0]   w;
    longint        num;
    longint        den;
    longint        mag;
    longint        q;
    num = 0;
    den = 0;
    r.near = '0;
    for (int i = 0; i < 7; i++) begin
      d = limit_q;
      if (enmask_q[i]) begin
        if (ok[i] && raw[i] < limit_q) d = raw[i];
        if (d < limit_q) r.near[i] = 1'b1;
        w = 33'((64'd1 << 32) / ((64'(d) << 10) + 64'd1));
        num += longint'(w) * (i - 3);
        den += longint'(w);
      end
      r.clamped[i] = d;
    end
    q = 0;
    if (den != 0) begin
      mag = (num < 0) ? -num : num;
      q = (mag <<< 12) / den;
      if (num < 0) q = -q;
    end
    r.perr = q[14:0];
    return r;
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  // result checker
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.clamped = m_axis_tdata[111:0];
      got.near = m_axis_tdata[118:112];
      got.perr = m_axis_tdata[133:119];
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        for (int i = 0; i < 7; i++)
          if (got.clamped[i] !== exp_r.clamped[i]) begin
            $error("clamped_%0d expected %0d got %0d", i, exp_r.clamped[i], got.clamped[i]);
            errors++;
          end
        if (got.near !== exp_r.near) begin
          $error("near_mask expected %h got %h", exp_r.near, got.near);
          errors++;
        end
        if (got.perr !== exp_r.perr) begin
          $error("position_error expected %0d got %0d",
                 $signed(exp_r.perr), $signed(got.perr));
          errors++;
        end
      end
    end
  end

  // send one frame, with random idle before it; valid stays up for a following item
  task automatic send_frame(dist_vec_t raw, logic [6:0] ok);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {1'b0, ok, raw};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_frame(raw, ok));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LIMIT) limit_q = val;
    else enmask_q = val[6:0];
    @(negedge clk_i);
  endtask

  function automatic dist_vec_t rand_dists(logic [15:0] lim);
    dist_vec_t v;
    for (int i = 0; i < 7; i++)
      case ($urandom_range(4))
        0: v[i] = 16'($urandom);
        1: v[i] = 16'($urandom_range(3));
        2: v[i] = lim;
        default: v[i] = (lim == 0) ? 16'd0 : 16'($urandom_range(lim));
      endcase
    return v;
  endfunction

  // extremes, several mask corners, no sensor enabled
  task automatic test_directed();
    dist_vec_t v;
    send_frame('0, 7'h7F);
    send_frame({7{16'hFFFF}}, 7'h7F);
    send_frame({7{16'hFFFF}}, 7'h00);
    v = '0;
    v[0] = 16'd0;
    for (int i = 1; i < 7; i++) v[i] = 16'hFFFF;
    send_frame(v, 7'h7F);
    v[0] = 16'hFFFF;
    v[6] = 16'd0;
    send_frame(v, 7'h7F);
    for (int i = 0; i < 7; i++) v[i] = 16'(i * 100 + 1);
    send_frame(v, 7'h55);
    send_frame(v, 7'h2A);
    send_frame({7{16'd999}}, 7'h7F);
    send_frame({7{16'd1000}}, 7'h7F);
    drain();
    write_reg(REG_ENMASK, 7'h00);
    send_frame(v, 7'h7F);
    drain();
    write_reg(REG_ENMASK, 7'h01);
    send_frame(v, 7'h7F);
    drain();
    write_reg(REG_LIMIT, 16'hFFFF);
    write_reg(REG_ENMASK, 7'h7F);
    send_frame({7{16'hFFFE}}, 7'h7F);
    send_frame({7{16'hAAAA}}, 7'h7F);
    send_frame({7{16'h5555}}, 7'h7F);
    drain();
    write_reg(REG_LIMIT, 16'd0);
    send_frame(v, 7'h7F);
    drain();
  endtask

  // random frames across settings and idling phases
  task automatic test_random();
    logic [15:0] lims[6] = '{16'd1000, 16'd0, 16'hFFFF, 16'd1, 16'd300, 16'd40000};
    int idle[4] = '{0, 65, 0, 30};
    int stall[4] = '{0, 0, 65, 30};
    for (int p = 0; p < 24; p++) begin
      drain();
      write_reg(REG_LIMIT, (p < 6) ? lims[p] : 16'($urandom));
      write_reg(REG_ENMASK, (p % 5 == 0) ? 7'h7F : 7'($urandom));
      send_idle_pct = idle[p % 4];
      recv_stall_pct = stall[p % 4];
      for (int n = 0; n < 75; n++)
        send_frame(rand_dists(limit_q), 7'($urandom));
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // long receiver hold-off while frames keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 120; n++) send_frame(rand_dists(limit_q), 7'($urandom));
    join
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    $display("ran %0d results over directed corners, random settings and idling", results_seen);
    $display("including a long output hold-off with the input stalled");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/idpe_pkg.sv
rtl/core/idpe_lane.sv
rtl/core/idpe_merge.sv
rtl/core/inverse_distance_position_estimator.sv
tb/inverse_distance_position_estimator_test.sv
